FILE: sv/ace_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants of the accumulator cpu execute block.
// ----------------------------------------------------------------------------
package ace_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int OPCODE_W    = 8;
    localparam int BASE_W      = 16;
    localparam int OUT_ADDR_W  = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_FIELD_W = 99;
    localparam int OUT_DATA_W  = 104;

    localparam logic [OPCODE_W-1:0] OPC_EXIT    = 8'd0;
    localparam logic [OPCODE_W-1:0] OPC_LDC     = 8'd1;
    localparam logic [OPCODE_W-1:0] OPC_ACC_BUF = 8'd2;
    localparam logic [OPCODE_W-1:0] OPC_ACC_ADR = 8'd3;
    localparam logic [OPCODE_W-1:0] OPC_BUF_ACC = 8'd4;
    localparam logic [OPCODE_W-1:0] OPC_ADR_ACC = 8'd5;
    localparam logic [OPCODE_W-1:0] OPC_LOAD    = 8'd6;
    localparam logic [OPCODE_W-1:0] OPC_STORE   = 8'd7;
    localparam logic [OPCODE_W-1:0] OPC_ADD     = 8'd8;
    localparam logic [OPCODE_W-1:0] OPC_MUL     = 8'd9;
    localparam logic [OPCODE_W-1:0] OPC_AND     = 8'd10;
    localparam logic [OPCODE_W-1:0] OPC_OR      = 8'd11;
    localparam logic [OPCODE_W-1:0] OPC_JNZ     = 8'd12;
    localparam logic [OPCODE_W-1:0] OPC_NOP     = 8'd13;

    typedef enum logic [3:0] {
        K_EXIT,
        K_LDC,
        K_ACC_BUF,
        K_ACC_ADR,
        K_BUF_ACC,
        K_ADR_ACC,
        K_LOAD,
        K_STORE,
        K_ADD,
        K_MUL,
        K_AND,
        K_OR,
        K_JNZ,
        K_NOP,
        K_BAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] load_data;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : ace_pkg
`default_nettype wire

FILE: sv/accumulator_cpu_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// Accumulator cpu core: one fetched instruction in, one result beat out.
// ----------------------------------------------------------------------------
// Each input beat carries an opcode, its operand word and the memory word at
// the current address register. The opcode is classified on entry and the
// beat waits in a two-entry queue; the execute stage retires one instruction
// per clock unless the output stalls, and registers the result. Sustained
// rate is one beat per cycle, bounded by the accumulator update loop, which
// holds a single 32x32 multiply. A stalled output leaves room for two more
// input beats before tready drops. base_address is written through cfg_wr_en
// and cfg_wr_data by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ace_pkg::BASE_W-1:0]      cfg_wr_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] opcode, [39:8] operand, [71:40] load_data
    input  wire logic [ace_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] fetch_address, [31:16] data_address, [32] write_enable,
    // [64:33] write_data, [96:65] accumulator_value, [97] halted,
    // [98] bad_opcode, [103:99] zero
    output logic [ace_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import ace_pkg::*;

    q_status_t q_status;
    q_entry_t  push_entry;
    q_entry_t  head;
    logic      push;
    logic      pop;

    ace_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    ace_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    ace_execute u_execute (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule : accumulator_cpu_execute
`default_nettype wire

FILE: sv/ace_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_front
// Input side: takes instruction beats and classifies the opcode.
// ----------------------------------------------------------------------------
module ace_front (
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] opcode, [39:8] operand, [71:40] load_data
    input  wire logic [ace_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire ace_pkg::q_status_t            q_status,
    output logic                               push,
    output ace_pkg::q_entry_t                  push_entry
);
    import ace_pkg::*;

    logic [OPCODE_W-1:0] opcode;
    op_kind_t            kind;

    assign opcode = s_axis_tdata[7:0];

    always_comb
    begin
        case (opcode)
            OPC_EXIT:    kind = K_EXIT;
            OPC_LDC:     kind = K_LDC;
            OPC_ACC_BUF: kind = K_ACC_BUF;
            OPC_ACC_ADR: kind = K_ACC_ADR;
            OPC_BUF_ACC: kind = K_BUF_ACC;
            OPC_ADR_ACC: kind = K_ADR_ACC;
            OPC_LOAD:    kind = K_LOAD;
            OPC_STORE:   kind = K_STORE;
            OPC_ADD:     kind = K_ADD;
            OPC_MUL:     kind = K_MUL;
            OPC_AND:     kind = K_AND;
            OPC_OR:      kind = K_OR;
            OPC_JNZ:     kind = K_JNZ;
            OPC_NOP:     kind = K_NOP;
            default:     kind = K_BAD;
        endcase
    end

    assign s_axis_tready        = !q_status.full;
    assign push                 = s_axis_tvalid && !q_status.full;
    assign push_entry.kind      = kind;
    assign push_entry.operand   = s_axis_tdata[39:8];
    assign push_entry.load_data = s_axis_tdata[71:40];

endmodule : ace_front
`default_nettype wire

FILE: sv/ace_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_queue
// Two-entry queue between the decode side and the execute side.
// ----------------------------------------------------------------------------
module ace_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ace_pkg::q_entry_t  push_entry,
    input  wire logic               pop,
    output ace_pkg::q_entry_t       head,
    output ace_pkg::q_status_t      status
);
    import ace_pkg::*;

    q_entry_t   entry_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg[1];
    assign status.empty = (count_reg == 2'd0);

endmodule : ace_queue
`default_nettype wire

FILE: sv/ace_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_execute
// Execute side: register file, instruction execution and output register.
// ----------------------------------------------------------------------------
module ace_execute (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ace_pkg::BASE_W-1:0]     cfg_wr_data,
    input  wire ace_pkg::q_entry_t              head,
    input  wire ace_pkg::q_status_t             q_status,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [ace_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import ace_pkg::*;

    logic [BASE_W-1:0]     base_reg;
    logic [WORD_W-1:0]     acc_reg;
    logic [WORD_W-1:0]     acc_next;
    logic [WORD_W-1:0]     buf_reg;
    logic [WORD_W-1:0]     buf_next;
    logic [WORD_W-1:0]     adr_reg;
    logic [WORD_W-1:0]     adr_next;
    logic [ADDR_BITS-1:0]  pc_reg;
    logic [ADDR_BITS-1:0]  pc_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [WORD_W-1:0]     product;
    logic [ADDR_BITS-1:0]  fetch_sum;
    logic                  wr_en;
    logic                  halt;
    logic                  bad;
    logic [WORD_W-1:0]     wr_data;

    assign product = acc_reg * buf_reg;
    assign pop     = !q_status.empty && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        acc_next = acc_reg;
        buf_next = buf_reg;
        adr_next = adr_reg;
        pc_next  = pc_reg + ADDR_BITS'(1);
        wr_en    = 1'b0;
        halt     = 1'b0;
        bad      = 1'b0;
        case (head.kind)
            K_EXIT:    halt     = 1'b1;
            K_LDC:     acc_next = head.operand;
            K_ACC_BUF: acc_next = buf_reg;
            K_ACC_ADR: acc_next = adr_reg;
            K_BUF_ACC: buf_next = acc_reg;
            K_ADR_ACC: adr_next = acc_reg;
            K_LOAD:    buf_next = head.load_data;
            K_STORE:   wr_en    = 1'b1;
            K_ADD:     acc_next = acc_reg + buf_reg;
            K_MUL:     acc_next = product;
            K_AND:     acc_next = WORD_W'((acc_reg != '0) && (buf_reg != '0));
            K_OR:      acc_next = WORD_W'((acc_reg != '0) || (buf_reg != '0));
            K_JNZ:
            begin
                if (acc_reg != '0)
                begin
                    pc_next = head.operand[ADDR_BITS-1:0];
                end
            end
            K_NOP:     ;
            default:   bad      = 1'b1;
        endcase
        wr_data        = wr_en ? buf_reg : '0;
        fetch_sum      = ADDR_BITS'(base_reg) + pc_next;
        out_valid_next = pop || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            acc_reg       <= '0;
            buf_reg       <= '0;
            adr_reg       <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                acc_reg <= acc_next;
                buf_reg <= buf_next;
                adr_reg <= adr_next;
                pc_reg  <= pc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {
                (OUT_DATA_W - OUT_FIELD_W)'(0),
                bad,
                halt,
                acc_next,
                wr_data,
                wr_en,
                OUT_ADDR_W'(adr_next[ADDR_BITS-1:0]),
                OUT_ADDR_W'(fetch_sum)
            };
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule : ace_execute
`default_nettype wire

FILE: sv/ace_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_checker
// Port-level checks of the accumulator cpu execute block.
// ----------------------------------------------------------------------------
module ace_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ace_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import ace_pkg::*;

    // stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // no write data without a write
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[64:33] == '0)
        else $error("write_data nonzero without write_enable");

    // halt, write and bad opcode come from different opcodes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $countones({m_axis_tdata[98], m_axis_tdata[97],
                                      m_axis_tdata[32]}) <= 1)
        else $error("more than one of halted, bad_opcode, write_enable");

    // padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_FIELD_W] == '0)
        else $error("tdata padding not zero");

endmodule : ace_checker

bind accumulator_cpu_execute ace_checker u_ace_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
